[src/dmssc_pkg.sv]
// Package for the dual motor step speed controller.
// Holds the beat payload structs, register indexes, command codes, reset values and the saturated speed.
// No dependencies.
package dmssc_pkg;

  // Register indexes on the configuration port.
  localparam logic CfgTargetSpeed = 1'b0;
  localparam logic CfgSpeedScale  = 1'b1;

  // Input command codes.
  localparam logic CmdStart  = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [14:0] TargetSpeedReset = 15'd60;
  localparam logic [15:0] SpeedScaleReset  = 16'd46875;

  // Speed reported for a zero period.
  localparam logic [15:0] SpeedMax = 16'hFFFF;

  // One input beat.
  typedef struct packed {
    logic        cmd;
    logic        motor;
    logic [15:0] period;
    logic [7:0]  start_duty;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic        which_motor;
    logic [15:0] measured_speed;
    logic [7:0]  duty_left;
    logic [7:0]  duty_right;
  } out_beat_t;

endpackage

[src/dual_motor_step_speed_control.sv]
// Dual motor step speed controller: one beat in, one result beat out.
// A start command or a zero period goes from accept straight to the finish state; a sample
// with a nonzero period first passes through the restoring divider, which makes one
// quotient bit per cycle over the 16 bits of speed_scale.
// Input stalls until a beat is done; the next beat is taken while a result waits.
// Reset (rst_ni low, asynchronous): both duties 0, target_speed 60, speed_scale 46875.
// Depends on dmssc_pkg.
module dual_motor_step_speed_control #(
  parameter int DUTY_BITS   = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dmssc_pkg::in_beat_t  in_data_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dmssc_pkg::out_beat_t out_data_o
);

  // Effective period width and the mask it gives on the 16-bit field.
  localparam int          PeriodWidth = (PERIOD_BITS < 16) ? PERIOD_BITS : 16;
  localparam logic [15:0] PeriodMask  = 16'((33'd1 << PeriodWidth) - 33'd1);

  // Controller states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [3:0]           cnt_q, cnt_d;
  logic                 cmd_q, cmd_d;
  logic                 motor_q, motor_d;
  logic [15:0]          div_q, div_d;
  logic [15:0]          rem_q, rem_d;
  logic [15:0]          dvd_q, dvd_d;
  logic [DUTY_BITS-1:0] start_q, start_d;
  logic [14:0]          target_q;
  logic [15:0]          scale_q;
  logic [DUTY_BITS-1:0] left_q, left_d;
  logic [DUTY_BITS-1:0] right_q, right_d;
  logic                 out_valid_q, out_valid_d;
  dmssc_pkg::out_beat_t out_q, out_d;

  logic                 in_beat;
  logic                 out_free;
  logic [15:0]          period_m;
  logic [16:0]          trial;
  logic                 qbit;
  logic [DUTY_BITS-1:0] duty_sel;
  logic [DUTY_BITS-1:0] duty_new;

  assign in_stall_o  = (state_q != StIdle);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign period_m    = in_data_i.period & PeriodMask;

  // One restoring divide step: shift in the next dividend bit and try the subtract.
  assign trial = {rem_q, dvd_q[15]};
  assign qbit  = (trial >= {1'b0, div_q});

  // Step the sampled motor's duty one toward the target, clamped to its range.
  always_comb begin
    duty_sel = motor_q ? right_q : left_q;
    duty_new = duty_sel;
    if ({1'b0, target_q} > dvd_q) begin
      if (duty_sel != '1) duty_new = duty_sel + DUTY_BITS'(1);
    end else if ({1'b0, target_q} < dvd_q) begin
      if (duty_sel != '0) duty_new = duty_sel - DUTY_BITS'(1);
    end
  end

  // Sequencer: accept, divide for a sample with a nonzero period, then write the result beat and the duties.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    motor_d     = motor_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    start_d     = start_q;
    left_d      = left_q;
    right_d     = right_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          cmd_d   = in_data_i.cmd;
          motor_d = in_data_i.motor;
          div_d   = period_m;
          rem_d   = '0;
          cnt_d   = '0;
          start_d = DUTY_BITS'(in_data_i.start_duty);
          if (in_data_i.cmd == dmssc_pkg::CmdStart) begin
            dvd_d   = '0;
            state_d = StFin;
          end else if (period_m == '0) begin
            dvd_d   = dmssc_pkg::SpeedMax;
            state_d = StFin;
          end else begin
            dvd_d   = scale_q;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        rem_d = qbit ? 16'(trial - {1'b0, div_q}) : trial[15:0];
        dvd_d = {dvd_q[14:0], qbit};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = StFin;
      end
      StFin: begin
        if (out_free) begin
          if (cmd_q == dmssc_pkg::CmdStart) begin
            left_d  = start_q;
            right_d = start_q;
          end else if (motor_q) begin
            right_d = duty_new;
          end else begin
            left_d  = duty_new;
          end
          out_d.which_motor    = (cmd_q == dmssc_pkg::CmdStart) ? 1'b0 : motor_q;
          out_d.measured_speed = dvd_q;
          out_d.duty_left      = 8'(left_d);
          out_d.duty_right     = 8'(right_d);
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state and duties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      left_q      <= '0;
      right_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      right_q     <= right_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= dmssc_pkg::TargetSpeedReset;
      scale_q  <= dmssc_pkg::SpeedScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmssc_pkg::CfgTargetSpeed: target_q <= cfg_data_i[14:0];
        dmssc_pkg::CfgSpeedScale:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    motor_q <= motor_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    start_q <= start_d;
    out_q   <= out_d;
  end

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> div_q != '0)
    else $error("divider running with zero divisor");

  // A start command skips the divider.
  a_start_skips_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.cmd == dmssc_pkg::CmdStart |=> state_q == StFin)
    else $error("start command did not go straight to finish");

  // The last divide step hands over to the finish state.
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv && cnt_q == 4'd15 |=> state_q == StFin)
    else $error("divider did not finish after sixteen steps");

  // A new result beat only comes out of the finish state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StFin)
    else $error("result beat raised outside finish state");

endmodule

[verif/dmssc_checker.sv]
// Checker for the dual motor step speed controller: watches both channels and
// the configuration port, predicts every result beat and compares it.
// Depends on dmssc_pkg.
module dmssc_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  dmssc_pkg::in_beat_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  dmssc_pkg::out_beat_t out_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int ReportLimit = 10;

  // Shadow copy of the registers and the two duties.
  logic [14:0] target_speed_q;
  logic [15:0] speed_scale_q;
  logic [7:0]  left_duty_q;
  logic [7:0]  right_duty_q;

  // Results predicted at input accept, oldest first.
  dmssc_pkg::out_beat_t expected_results_q[$];
  dmssc_pkg::out_beat_t oldest_result;

  // Moves a duty one step toward the target, holding it within 0..255.
  function automatic logic [7:0] step_toward_target(logic [7:0] duty, logic [15:0] speed);
    logic [7:0] next_duty;
    next_duty = duty;
    if ({1'b0, target_speed_q} > speed) begin
      if (duty != 8'hFF) next_duty = duty + 8'd1;
    end else if ({1'b0, target_speed_q} < speed) begin
      if (duty != 8'h00) next_duty = duty - 8'd1;
    end
    return next_duty;
  endfunction

  // Applies one input beat to the duties and returns the result it causes.
  function automatic dmssc_pkg::out_beat_t predict_duty_update(dmssc_pkg::in_beat_t beat);
    dmssc_pkg::out_beat_t res;
    logic [15:0]          speed;
    speed = '0;
    res.which_motor = 1'b0;
    if (beat.cmd == dmssc_pkg::CmdStart) begin
      left_duty_q  = beat.start_duty;
      right_duty_q = beat.start_duty;
    end else begin
      // A zero period saturates; otherwise the quotient always fits 16 bits.
      if (beat.period == 16'd0) speed = dmssc_pkg::SpeedMax;
      else speed = speed_scale_q / beat.period;
      res.which_motor = beat.motor;
      if (beat.motor == 1'b0) left_duty_q = step_toward_target(left_duty_q, speed);
      else right_duty_q = step_toward_target(right_duty_q, speed);
    end
    res.measured_speed = speed;
    res.duty_left      = left_duty_q;
    res.duty_right     = right_duty_q;
    return res;
  endfunction

  // Counts a failure and reports it while under the report limit.
  task automatic note_mismatch(string field, int exp_val, int act_val);
    fail_count_o = fail_count_o + 1;
    if (fail_count_o <= ReportLimit)
      $display("mismatch on %s: expected %0d, got %0d", field, exp_val, act_val);
  endtask

  // Track registers, compare accepted result beats, queue predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_speed_q = dmssc_pkg::TargetSpeedReset;
      speed_scale_q  = dmssc_pkg::SpeedScaleReset;
      left_duty_q    = '0;
      right_duty_q   = '0;
      expected_results_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dmssc_pkg::CfgTargetSpeed: target_speed_q = cfg_data_i[14:0];
          dmssc_pkg::CfgSpeedScale:  speed_scale_q  = cfg_data_i;
          default: ;
        endcase
      end

      // The result beat always belongs to an earlier input, so compare first.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= ReportLimit)
            $display("unexpected result beat: %h", out_data_i);
        end else begin
          oldest_result = expected_results_q.pop_front();
          if (out_data_i.which_motor !== oldest_result.which_motor)
            note_mismatch("which_motor", int'(oldest_result.which_motor),
                          int'(out_data_i.which_motor));
          if (out_data_i.measured_speed !== oldest_result.measured_speed)
            note_mismatch("measured_speed", int'(oldest_result.measured_speed),
                          int'(out_data_i.measured_speed));
          if (out_data_i.duty_left !== oldest_result.duty_left)
            note_mismatch("duty_left", int'(oldest_result.duty_left),
                          int'(out_data_i.duty_left));
          if (out_data_i.duty_right !== oldest_result.duty_right)
            note_mismatch("duty_right", int'(oldest_result.duty_right),
                          int'(out_data_i.duty_right));
        end
      end

      if (in_valid_i && !in_stall_i)
        expected_results_q.push_back(predict_duty_update(in_data_i));

      pending_o = expected_results_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// Top of the testbench for the dual motor step speed controller: clock, reset,
// stimulus, receiver stalls, watchdog and the verdict.
// Depends on dmssc_pkg, dual_motor_step_speed_control and dmssc_checker.
module testbench;

  localparam int ClkHalf       = 6;
  localparam int ResetCycles   = 6;
  // Longest correct quiet stretch is a divide plus a stall plus a gap, well under the limit.
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 24;
  localparam int RandomPhases  = 5;
  localparam int PhaseItems    = 100;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_idx   = dmssc_pkg::CfgTargetSpeed;
  logic [15:0]          cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  dmssc_pkg::in_beat_t  in_data   = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  dmssc_pkg::out_beat_t out_data;
  int                   fail_count;
  int                   pending_results;

  // Current register values, used to aim sample periods near the target.
  logic [14:0] cur_target = dmssc_pkg::TargetSpeedReset;
  logic [15:0] cur_scale  = dmssc_pkg::SpeedScaleReset;

  dual_motor_step_speed_control u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  dmssc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Receiver stalls on its own pattern: short stalls, short and long open stretches.
  int stall_run = 0;
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      if (out_stall) begin
        out_stall <= 1'b0;
        stall_run <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                 : int'($urandom_range(1, 10));
      end else begin
        out_stall <= 1'b1;
        stall_run <= int'($urandom_range(1, 8));
      end
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one beat and returns at the edge that accepts it.
  task automatic send_beat(dmssc_pkg::in_beat_t beat);
    in_data  <= beat;
    in_valid <= 1'b1;
    // Stall read right after the edge still holds the value the block sampled.
    do @(posedge clk_i); while (in_stall);
  endtask

  // Waits until every predicted result has arrived and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges; call only while idle.
  task automatic write_regs(logic [14:0] target, logic [15:0] scale);
    cfg_we   <= 1'b1;
    cfg_idx  <= dmssc_pkg::CfgTargetSpeed;
    cfg_data <= {1'b0, target};
    @(posedge clk_i);
    cfg_idx  <= dmssc_pkg::CfgSpeedScale;
    cfg_data <= scale;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_target = target;
    cur_scale  = scale;
  endtask

  function automatic dmssc_pkg::in_beat_t sample_beat(logic motor, logic [15:0] period);
    dmssc_pkg::in_beat_t beat;
    beat.cmd        = dmssc_pkg::CmdSample;
    beat.motor      = motor;
    beat.period     = period;
    beat.start_duty = 8'($urandom_range(0, 255));
    return beat;
  endfunction

  // Start beat with random contents in the fields it ignores.
  function automatic dmssc_pkg::in_beat_t start_beat(logic [7:0] duty);
    dmssc_pkg::in_beat_t beat;
    beat.cmd        = dmssc_pkg::CmdStart;
    beat.motor      = 1'($urandom_range(0, 1));
    beat.period     = 16'($urandom_range(0, 65535));
    beat.start_duty = duty;
    return beat;
  endfunction

  // Periods: zero, full range, small, and otherwise close to where speed meets target.
  function automatic logic [15:0] pick_period();
    int near;
    int choice;
    choice = int'($urandom_range(0, 9));
    if (choice == 0) return 16'd0;
    if (choice <= 2) return 16'($urandom_range(0, 65535));
    if (choice <= 4) return 16'($urandom_range(1, 255));
    if (cur_target == 0) return 16'($urandom_range(0, 65535));
    near = int'(cur_scale / cur_target) + int'($urandom_range(0, 4)) - 2;
    if (near < 1) near = 1;
    if (near > 65535) near = 65535;
    return near[15:0];
  endfunction

  function automatic logic [7:0] pick_duty();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus sequence and verdict.
  initial begin
    int sent;
    int burst;
    int gap;
    logic [14:0] target;
    logic [15:0] scale;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: saturation, both duty limits, speed equal to target.
    send_beat(start_beat(8'h00));
    send_beat(sample_beat(1'b0, 16'd0));
    send_beat(sample_beat(1'b1, 16'd0));
    send_beat(start_beat(8'hFF));
    send_beat(sample_beat(1'b0, 16'hFFFF));
    send_beat(sample_beat(1'b1, 16'hFFFF));
    send_beat(sample_beat(1'b0, 16'd781));
    send_beat(sample_beat(1'b1, 16'd1));
    send_beat(start_beat(8'hAA));
    send_beat(sample_beat(1'b0, 16'h5555));
    send_beat(sample_beat(1'b1, 16'hAAAA));
    send_beat(start_beat(8'h55));
    send_beat(sample_beat(1'b1, 16'h8000));
    settle();

    // Stop target: zero speed holds, any speed pulls the duty down.
    write_regs(15'd0, dmssc_pkg::SpeedScaleReset);
    send_beat(start_beat(8'h80));
    send_beat(sample_beat(1'b0, 16'hFFFF));
    send_beat(sample_beat(1'b0, 16'd100));
    settle();

    // Largest registers: maximum speed, equality at half scale, speed below target.
    write_regs(15'h7FFF, 16'hFFFF);
    send_beat(sample_beat(1'b1, 16'd1));
    send_beat(sample_beat(1'b1, 16'd2));
    send_beat(sample_beat(1'b0, 16'd3));
    settle();

    // Zero scale gives zero speed except on a zero period.
    write_regs(15'd1000, 16'd0);
    send_beat(sample_beat(1'b0, 16'd5));
    send_beat(sample_beat(1'b1, 16'd0));
    settle();

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 5))
        0:       target = 15'd0;
        1:       target = 15'h7FFF;
        2:       target = 15'($urandom_range(0, 32767));
        default: target = 15'($urandom_range(1, 2000));
      endcase
      case ($urandom_range(0, 4))
        0:       scale = 16'hFFFF;
        1:       scale = 16'd1;
        default: scale = 16'($urandom_range(1, 65535));
      endcase
      write_regs(target, scale);

      sent = 0;
      while (sent < PhaseItems) begin
        burst = int'($urandom_range(1, 20));
        for (int i = 0; i < burst && sent < PhaseItems; i++) begin
          if ($urandom_range(0, 9) == 0) send_beat(start_beat(pick_duty()));
          else send_beat(sample_beat(1'($urandom_range(0, 1)), pick_period()));
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      settle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
